### rtl/circular_deque_engine_core_defines.svh
// ----------------------------------------------------------------------------
// Circular deque engine: assertion macros
// Shared concurrent assertion forms used by the deque engine RTL.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_ENGINE_CORE_DEFINES_SVH
`define CIRCULAR_DEQUE_ENGINE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cde_pkg.sv
// ----------------------------------------------------------------------------
// Circular deque engine package
// Shared constants, codes, request structures and index helper functions.
// ----------------------------------------------------------------------------
package cde_pkg;

    localparam int DEPTH  = 128;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int SIZE_W = 8;
    localparam int CMD_W  = 2;
    localparam int MODE_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_RIGHT = 2'd0,
        CMD_INS_LEFT  = 2'd1,
        CMD_DEL_LEFT  = 2'd2,
        CMD_DEL_RIGHT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_DENIED = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        CFG_DEQUE_SIZE    = 1'b0,
        CFG_RESTRICT_MODE = 1'b1
    } cfg_idx_t;

    localparam logic [MODE_W-1:0] MODE_NO_LEFT_INS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NO_LEFT_DEL = 2'd2;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        status_t status;
        logic    now_empty;
        logic    now_full;
    } step_res_t;

    // Move one place to the right, wrapping at the active size.
    function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0]  idx,
                                                 input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] nxt;
        nxt = SIZE_W'(idx) + SIZE_W'(1);
        return (nxt >= size) ? '0 : IDX_W'(nxt);
    endfunction

    // Move one place to the left, wrapping to the last active slot.
    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0]  idx,
                                                   input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] last;
        last = size - SIZE_W'(1);
        return (idx == '0) ? IDX_W'(last) : idx - IDX_W'(1);
    endfunction

endpackage

### rtl/cde_ram.sv
// ----------------------------------------------------------------------------
// Circular deque engine: slot memory
// Single-port synchronous RAM with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module cde_ram #(
    parameter int DEPTH_P = 128,
    parameter int WIDTH_P = 32
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH_P)-1:0] addr,
    input  logic [WIDTH_P-1:0]         wdata,
    output logic [WIDTH_P-1:0]         rdata
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];
    logic [WIDTH_P-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/cde_ctrl.sv
// ----------------------------------------------------------------------------
// Circular deque engine: pointer control
// Holds the head and tail indices, the empty flag and the configuration,
// decides each command and issues the slot memory access.
// ----------------------------------------------------------------------------
module cde_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [cde_pkg::CMD_W-1:0]  command,
    input  logic [cde_pkg::DATA_W-1:0] value,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [cde_pkg::SIZE_W-1:0] cfg_data,
    output cde_pkg::mem_req_t         mem_req,
    output cde_pkg::step_res_t        res
);

    logic [cde_pkg::IDX_W-1:0]  head_reg, head_next;
    logic [cde_pkg::IDX_W-1:0]  tail_reg, tail_next;
    logic                       empty_reg, empty_next;
    logic [cde_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [cde_pkg::MODE_W-1:0] mode_reg;
    cde_pkg::cmd_t              cmd;
    cde_pkg::status_t           status;
    logic                       denied;
    logic                       is_ins;
    logic                       full_now;
    logic                       wr_en;
    logic                       rd_en;
    logic [cde_pkg::IDX_W-1:0]  addr;

    // Size is clamped into the range 1..DEPTH when it is written.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            size_next = cde_pkg::SIZE_W'(1);
        end
        else if (cfg_data > cde_pkg::SIZE_W'(cde_pkg::DEPTH))
        begin
            size_next = cde_pkg::SIZE_W'(cde_pkg::DEPTH);
        end
        else
        begin
            size_next = cfg_data;
        end
    end

    always_comb
    begin
        cmd        = cde_pkg::cmd_t'(command);
        denied     = ((mode_reg == cde_pkg::MODE_NO_LEFT_INS) && (cmd == cde_pkg::CMD_INS_LEFT)) ||
                     ((mode_reg == cde_pkg::MODE_NO_LEFT_DEL) && (cmd == cde_pkg::CMD_DEL_LEFT));
        is_ins     = (cmd == cde_pkg::CMD_INS_RIGHT) || (cmd == cde_pkg::CMD_INS_LEFT);
        full_now   = !empty_reg && (cde_pkg::step_up(tail_reg, size_reg) == head_reg);
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        status     = cde_pkg::ST_DONE;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        addr       = '0;

        if (denied)
        begin
            status = cde_pkg::ST_DENIED;
        end
        else if (is_ins)
        begin
            if (full_now)
            begin
                status = cde_pkg::ST_FULL;
            end
            else
            begin
                wr_en = 1'b1;
                if (empty_reg)
                begin
                    // First element always lands in slot zero.
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b0;
                    addr       = '0;
                end
                else if (cmd == cde_pkg::CMD_INS_RIGHT)
                begin
                    tail_next = cde_pkg::step_up(tail_reg, size_reg);
                    addr      = tail_next;
                end
                else
                begin
                    head_next = cde_pkg::step_down(head_reg, size_reg);
                    addr      = head_next;
                end
            end
        end
        else
        begin
            if (empty_reg)
            begin
                status = cde_pkg::ST_EMPTY;
            end
            else
            begin
                rd_en = 1'b1;
                addr  = (cmd == cde_pkg::CMD_DEL_LEFT) ? head_reg : tail_reg;
                if (head_reg == tail_reg)
                begin
                    // Last element leaves; the indices keep their values.
                    empty_next = 1'b1;
                end
                else if (cmd == cde_pkg::CMD_DEL_LEFT)
                begin
                    head_next = cde_pkg::step_up(head_reg, size_reg);
                end
                else
                begin
                    tail_next = cde_pkg::step_down(tail_reg, size_reg);
                end
            end
        end
    end

    assign mem_req.wr_en = step && wr_en;
    assign mem_req.rd_en = step && rd_en;
    assign mem_req.addr  = addr;
    assign mem_req.wdata = value;

    assign res.status    = status;
    assign res.now_empty = empty_next;
    assign res.now_full  = !empty_next &&
                           (cde_pkg::step_up(tail_next, size_reg) == head_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            size_reg  <= cde_pkg::SIZE_W'(cde_pkg::DEPTH);
            mode_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cde_pkg::cfg_idx_t'(cfg_index))
                cde_pkg::CFG_DEQUE_SIZE:
                begin
                    size_reg  <= size_next;
                    head_reg  <= '0;
                    tail_reg  <= '0;
                    empty_reg <= 1'b1;
                end
                cde_pkg::CFG_RESTRICT_MODE:
                begin
                    mode_reg <= cfg_data[cde_pkg::MODE_W-1:0];
                end
                default:
                begin
                    mode_reg <= mode_reg;
                end
            endcase
        end
        else if (step)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

endmodule

### rtl/circular_deque_engine_core.sv
// ----------------------------------------------------------------------------
// Circular deque engine core
// Double-ended queue in a circular slot memory with a configurable capacity.
// ----------------------------------------------------------------------------
// Each accepted request is one command: insert right, insert left, delete
// left or delete right, and it produces exactly one result carrying a status,
// the removed value (zero unless a delete succeeded) and the empty and full
// flags after the command. Inserts and refused commands can be issued back
// to back; a successful delete holds off the next request, because the removed
// element comes out of the slot memory in the cycle after the read is issued,
// and no new request is taken during that read. The
// output register holds a finished result until it is taken, and a new
// request is accepted in the same cycle as the old result leaves. Writing
// deque_size empties the deque; both registers may only be written while
// the engine is idle. There is no clearing pass after reset: only slots that
// have been written are ever read.
// ----------------------------------------------------------------------------
`include "circular_deque_engine_core_defines.svh"

module circular_deque_engine_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // Command requests
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       command,
    input  logic signed [31:0]               value,
    // Results
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic signed [31:0]               removed_value,
    output logic                             now_empty,
    output logic                             now_full,
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [0:0]                       cfg_index,
    input  logic [7:0]                       cfg_data
);

    cde_pkg::mem_req_t          mem_req;
    cde_pkg::step_res_t         res;
    logic [cde_pkg::DATA_W-1:0] rdata;
    logic                       step;
    logic                       cfg_we;

    // A delete whose read is in flight waits here for the memory data.
    logic                       pend_reg;
    cde_pkg::step_res_t         pend_res_reg;

    logic                       out_valid_reg;
    cde_pkg::step_res_t         out_res_reg;
    logic [cde_pkg::DATA_W-1:0] out_data_reg;

    // A new request is taken when no read is outstanding and the output
    // register is either empty or being emptied in this cycle.
    assign in_ready  = !pend_reg && (!out_valid_reg || out_ready);
    assign cfg_ready = !pend_reg;
    assign step      = in_valid && in_ready;
    assign cfg_we    = cfg_valid && cfg_ready;

    cde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .command   (command),
        .value     (cde_pkg::DATA_W'(value)),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mem_req   (mem_req),
        .res       (res)
    );

    cde_ram #(
        .DEPTH_P (cde_pkg::DEPTH),
        .WIDTH_P (cde_pkg::DATA_W)
    ) u_ram (
        .clk   (clk),
        .wr_en (mem_req.wr_en),
        .rd_en (mem_req.rd_en),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (rdata)
    );

    // Control: the read flag and the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (pend_reg)
        begin
            // The output register was freed when the delete was accepted.
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            pend_reg      <= mem_req.rd_en;
            out_valid_reg <= !mem_req.rd_en;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload: results of inserts and refused commands load directly, successful
    // deletes load in the next cycle together with the memory data.
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            out_res_reg  <= pend_res_reg;
            out_data_reg <= rdata;
        end
        else if (step)
        begin
            pend_res_reg <= res;
            out_res_reg  <= res;
            out_data_reg <= '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_res_reg.status;
    assign removed_value = $signed(out_data_reg);
    assign now_empty     = out_res_reg.now_empty;
    assign now_full      = out_res_reg.now_full;

    // A memory read is outstanding for exactly one cycle.
    `CDE_ASSERT_NEXT(a_pend_one_cycle, clk, rst_n, pend_reg, !pend_reg,
        "memory read outstanding for more than one cycle")
    // The returning read never finds the output register occupied.
    `CDE_ASSERT_SAME(a_pend_out_free, clk, rst_n, pend_reg, !out_valid_reg,
        "read data returned while the output register was occupied")
    // A result never reports the deque as both empty and full.
    `CDE_ASSERT_SAME(a_flags_exclusive, clk, rst_n, out_valid_reg,
        !(out_res_reg.now_empty && out_res_reg.now_full),
        "result flags empty and full both set")
    // A pending read always belongs to a successful delete.
    `CDE_ASSERT_SAME(a_pend_done, clk, rst_n, pend_reg,
        pend_res_reg.status == cde_pkg::ST_DONE,
        "memory read pending for a refused command")

endmodule
